[rtl/core/rgb_hsv_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// RGB to HSV package
// Shared types and constants for the RGB to HSV pixel converter.
// ----------------------------------------------------------------------------
package rgb_hsv_pkg;

	// Hue is given in 64ths of ten degrees: the full circle is 36 * 64 units.
	localparam int unsigned HUE_W = 12;
	// Quotient bits of the hue fraction: 384 * |diff| / delta never exceeds 384.
	localparam int unsigned HUE_Q_W = 9;

	localparam logic [HUE_W-1:0] HUE_SEXTANT = 12'd384;
	localparam logic [HUE_W-1:0] HUE_GREEN_BASE = 12'd768;
	localparam logic [HUE_W-1:0] HUE_BLUE_BASE = 12'd1536;
	localparam logic [HUE_W-1:0] HUE_CIRCLE = 12'd2304;

	// Channel that holds the maximum; red wins ties over green, green over blue.
	typedef enum logic [1:0] {
		SECT_RED = 2'd0,
		SECT_GREEN = 2'd1,
		SECT_BLUE = 2'd2
	} sector_t;

	// Information that travels beside the hue division.
	typedef struct packed {
		sector_t sector;
		logic neg;
		logic undef;
	} hue_side_t;

endpackage : rgb_hsv_pkg
`default_nettype wire

[rtl/core/rgb_hsv_divider.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// RGB to HSV pipelined divider
// Restoring division, one quotient bit per register stage, with a sideband
// vector that travels beside the operands.
// ----------------------------------------------------------------------------
module rgb_hsv_divider #(
	parameter int unsigned DEN_W = 8,
	parameter int unsigned QW = 9,
	parameter int unsigned SIDE_W = 4
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic adv,
	input wire logic in_valid,
	input wire logic [DEN_W+QW-1:0] num,
	input wire logic [DEN_W-1:0] den,
	input wire logic [SIDE_W-1:0] side,
	output logic out_valid,
	output logic [QW-1:0] quot,
	output logic [DEN_W-1:0] rem,
	output logic [SIDE_W-1:0] out_side
);
	// The numerator must be below den * 2**QW; its upper DEN_W bits seed the remainder.

	logic [QW-1:0] valid_s;
	logic [DEN_W-1:0] rem_s [QW];
	logic [QW-1:0] low_s [QW];
	logic [QW-1:0] quot_s [QW];
	logic [DEN_W-1:0] den_s [QW];
	logic [SIDE_W-1:0] side_s [QW];

	logic [DEN_W-1:0] rem_prev [QW];
	logic [QW-1:0] low_prev [QW];
	logic [QW-1:0] quot_prev [QW];
	logic [DEN_W-1:0] den_prev [QW];
	logic [SIDE_W-1:0] side_prev [QW];

	logic [DEN_W-1:0] rem_next [QW];
	logic [QW-1:0] low_next [QW];
	logic [QW-1:0] quot_next [QW];

	// Operands seen by each stage: the ports for the first, the prior stage otherwise.
	always_comb begin
		rem_prev[0] = num[DEN_W+QW-1:QW];
		low_prev[0] = num[QW-1:0];
		quot_prev[0] = '0;
		den_prev[0] = den;
		side_prev[0] = side;
		for (int k = 1; k < QW; k++) begin
			rem_prev[k] = rem_s[k-1];
			low_prev[k] = low_s[k-1];
			quot_prev[k] = quot_s[k-1];
			den_prev[k] = den_s[k-1];
			side_prev[k] = side_s[k-1];
		end
	end

	// One trial subtraction per stage.
	always_comb begin
		logic [DEN_W:0] trial;
		logic [DEN_W:0] diff;
		logic ge;
		for (int k = 0; k < QW; k++) begin
			trial = {rem_prev[k], low_prev[k][QW-1]};
			diff = trial - {1'b0, den_prev[k]};
			ge = (trial >= {1'b0, den_prev[k]});
			rem_next[k] = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
			low_next[k] = {low_prev[k][QW-2:0], 1'b0};
			quot_next[k] = {quot_prev[k][QW-2:0], ge};
		end
	end

	// Valid bits move with the data and hold while the pipeline is stalled.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s <= '0;
		end else if (adv) begin
			valid_s <= {valid_s[QW-2:0], in_valid};
		end
	end

	// Stage payload registers.
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < QW; k++) begin
				rem_s[k] <= rem_next[k];
				low_s[k] <= low_next[k];
				quot_s[k] <= quot_next[k];
				den_s[k] <= den_prev[k];
				side_s[k] <= side_prev[k];
			end
		end
	end

	assign out_valid = valid_s[QW-1];
	assign quot = quot_s[QW-1];
	assign rem = rem_s[QW-1];
	assign out_side = side_s[QW-1];

	// The final remainder is always below a nonzero divisor.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (den_s[QW-1] != '0)) |-> (rem < den_s[QW-1]))
		else $error("divider remainder not below divisor");

	// A stall freezes every valid bit.
	assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> (valid_s == $past(valid_s)))
		else $error("divider valid bits moved during a stall");

	// A transaction that enters lands in the first stage.
	assert property (@(posedge clk) disable iff (!arst_n)
		(adv && in_valid) |=> valid_s[0])
		else $error("divider dropped an entering transaction");

endmodule : rgb_hsv_divider
`default_nettype wire

[rtl/core/rgb_to_hsv_converter.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// RGB to HSV converter
// Converts one RGB pixel per clock while the output is not stalled into hue
// (64ths of ten degrees), saturation and brightness, with a flag for grey pixels.
// ----------------------------------------------------------------------------
// Channel  | Direction | Handshake            | Payload
// input    | in        | in_valid / in_ready   | red, green, blue
// output   | out       | out_valid / out_ready | hue, saturation, brightness,
//          |           |                       | hue_undefined
//
// One transaction is accepted per clock while the output is not stalled; each
// passes stage 1, stage 2, the bit-per-stage dividers and the output register.
// The whole pipeline advances together; in_ready is high whenever the output
// register is empty or being taken, so a stall holds every stage in place.
// Reset clears only the valid bits; no data is lost or repeated across stalls.
// ----------------------------------------------------------------------------
module rgb_to_hsv_converter #(
	parameter int unsigned CHANNEL_BITS = 8
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire logic [CHANNEL_BITS-1:0] red,
	input wire logic [CHANNEL_BITS-1:0] green,
	input wire logic [CHANNEL_BITS-1:0] blue,
	output logic out_valid,
	input wire logic out_ready,
	output logic [rgb_hsv_pkg::HUE_W-1:0] hue,
	output logic [CHANNEL_BITS-1:0] saturation,
	output logic [CHANNEL_BITS-1:0] brightness,
	output logic hue_undefined
);
	import rgb_hsv_pkg::*;

	localparam int unsigned N = CHANNEL_BITS;
	localparam int unsigned QW = (N > HUE_Q_W) ? N : HUE_Q_W;
	localparam int unsigned NUM_W = N + QW;
	localparam int unsigned SIDE_W = $bits(hue_side_t);

	logic adv;

	// Stage 1: maximum, minimum and sector.
	logic valid_s1;
	logic [N-1:0] red_s1, green_s1, blue_s1, mx_s1, mn_s1;
	sector_t sector_s1;

	// Stage 2: numerators and divisors.
	logic valid_s2;
	logic [NUM_W-1:0] sat_num_s2, hue_num_s2;
	logic [N-1:0] mx_s2, delta_s2;
	hue_side_t side_s2;

	logic [N-1:0] mx_c, mn_c;
	sector_t sector_c;
	logic [N-1:0] delta_c, abs_c;
	logic [N:0] diff_c;
	logic [2*N-1:0] sat_prod_c;

	logic sat_valid, hue_valid;
	logic [QW-1:0] sat_quot, hue_quot;
	logic [N-1:0] sat_rem, hue_rem, bright_out;
	logic [SIDE_W-1:0] hue_side_vec;
	hue_side_t hue_side;

	logic [HUE_W-1:0] base_c, mag_c, hue_c;

	logic out_valid_q;
	logic [HUE_W-1:0] hue_q;
	logic [N-1:0] sat_q, bright_q;
	logic undef_q;

	// The pipeline moves whenever the output register can take a result.
	assign adv = out_ready || !out_valid_q;
	assign in_ready = adv;

	// Largest and smallest channel, and which channel leads.
	always_comb begin
		mx_c = (red > green) ? red : green;
		mx_c = (mx_c > blue) ? mx_c : blue;
		mn_c = (red < green) ? red : green;
		mn_c = (mn_c < blue) ? mn_c : blue;
		if ((red >= green) && (red >= blue)) begin
			sector_c = SECT_RED;
		end else if (green >= blue) begin
			sector_c = SECT_GREEN;
		end else begin
			sector_c = SECT_BLUE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			red_s1 <= red;
			green_s1 <= green;
			blue_s1 <= blue;
			mx_s1 <= mx_c;
			mn_s1 <= mn_c;
			sector_s1 <= sector_c;
		end
	end

	// Delta, signed channel difference of the sector and the two numerators.
	always_comb begin
		delta_c = mx_s1 - mn_s1;
		case (sector_s1)
			SECT_RED: diff_c = {1'b0, green_s1} - {1'b0, blue_s1};
			SECT_GREEN: diff_c = {1'b0, blue_s1} - {1'b0, red_s1};
			SECT_BLUE: diff_c = {1'b0, red_s1} - {1'b0, green_s1};
			default: diff_c = '0;
		endcase
		abs_c = diff_c[N] ? N'(-diff_c) : diff_c[N-1:0];
		// delta * (2**N - 1) as a shift and subtract.
		sat_prod_c = {delta_c, {N{1'b0}}} - (2*N)'(delta_c);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sat_num_s2 <= NUM_W'(sat_prod_c);
			// 384 * |diff| as two shifted terms.
			hue_num_s2 <= (NUM_W'(abs_c) << 8) + (NUM_W'(abs_c) << 7);
			mx_s2 <= mx_s1;
			delta_s2 <= delta_c;
			side_s2.sector <= sector_s1;
			side_s2.neg <= diff_c[N];
			side_s2.undef <= (delta_c == '0);
		end
	end

	// Saturation divider: delta * channel maximum over max.
	rgb_hsv_divider #(
		.DEN_W(N),
		.QW(QW),
		.SIDE_W(N)
	) u_sat_div (
		.clk(clk),
		.arst_n(arst_n),
		.adv(adv),
		.in_valid(valid_s2),
		.num(sat_num_s2),
		.den(mx_s2),
		.side(mx_s2),
		.out_valid(sat_valid),
		.quot(sat_quot),
		.rem(sat_rem),
		.out_side(bright_out)
	);

	// Hue divider: 384 * |diff| over delta.
	rgb_hsv_divider #(
		.DEN_W(N),
		.QW(QW),
		.SIDE_W(SIDE_W)
	) u_hue_div (
		.clk(clk),
		.arst_n(arst_n),
		.adv(adv),
		.in_valid(valid_s2),
		.num(hue_num_s2),
		.den(delta_s2),
		.side(side_s2),
		.out_valid(hue_valid),
		.quot(hue_quot),
		.rem(hue_rem),
		.out_side(hue_side_vec)
	);

	assign hue_side = hue_side_t'(hue_side_vec);

	// Hue assembly: sector base plus or minus the floored fraction.
	always_comb begin
		case (hue_side.sector)
			SECT_RED: base_c = hue_side.neg ? HUE_CIRCLE : '0;
			SECT_GREEN: base_c = HUE_GREEN_BASE;
			SECT_BLUE: base_c = HUE_BLUE_BASE;
			default: base_c = '0;
		endcase
		// A negative fraction floors away from zero when the division is inexact.
		mag_c = HUE_W'(hue_quot[HUE_Q_W-1:0])
			+ HUE_W'(hue_side.neg && (hue_rem != '0));
		hue_c = hue_side.neg ? (base_c - mag_c) : (base_c + mag_c);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= hue_valid;
		end
	end

	// Output register; grey pixels read zero hue and saturation.
	always_ff @(posedge clk) begin
		if (adv) begin
			hue_q <= hue_side.undef ? '0 : hue_c;
			sat_q <= hue_side.undef ? '0 : sat_quot[N-1:0];
			bright_q <= bright_out;
			undef_q <= hue_side.undef;
		end
	end

	assign out_valid = out_valid_q;
	assign hue = hue_q;
	assign saturation = sat_q;
	assign brightness = bright_q;
	assign hue_undefined = undef_q;

	// Both dividers carry the same transactions in lockstep.
	assert property (@(posedge clk) disable iff (!arst_n)
		sat_valid == hue_valid)
		else $error("divider pipelines out of step");

	// A defined hue lies on the circle, and a colored pixel has saturation.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !hue_undefined) |-> ((hue < HUE_CIRCLE) && (saturation != '0)))
		else $error("colored pixel with hue off the circle or no saturation");

	// A grey pixel reads zero hue and zero saturation.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && hue_undefined) |-> ((hue == '0) && (saturation == '0)))
		else $error("grey pixel with nonzero hue or saturation");

	// The saturation remainder never reaches a nonzero maximum.
	assert property (@(posedge clk) disable iff (!arst_n)
		(sat_valid && (bright_out != '0)) |-> (sat_rem < bright_out))
		else $error("saturation remainder out of range");

endmodule : rgb_to_hsv_converter
`default_nettype wire

[tb/sv/hsv_result_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HSV result checker
// Watches both channels of the RGB to HSV converter. Every accepted pixel is
// converted to its expected hue, saturation and brightness by an independent
// integer model. Every accepted result is compared with the oldest waiting
// expectation.
// ----------------------------------------------------------------------------
module hsv_result_checker #(
	parameter int unsigned CHANNEL_BITS = 8
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_ready,
	input wire logic [CHANNEL_BITS-1:0] red,
	input wire logic [CHANNEL_BITS-1:0] green,
	input wire logic [CHANNEL_BITS-1:0] blue,
	input wire logic out_valid,
	input wire logic out_ready,
	input wire logic [rgb_hsv_pkg::HUE_W-1:0] hue,
	input wire logic [CHANNEL_BITS-1:0] saturation,
	input wire logic [CHANNEL_BITS-1:0] brightness,
	input wire logic hue_undefined,
	output int fail_count,
	output int pending_count
);

	localparam longint CHANNEL_MAX = (longint'(1) << CHANNEL_BITS) - 1;

	typedef struct packed {
		logic [rgb_hsv_pkg::HUE_W-1:0] hue;
		logic [CHANNEL_BITS-1:0] saturation;
		logic [CHANNEL_BITS-1:0] brightness;
		logic hue_undefined;
	} hsv_pixel_t;

	// Expected results in the order their pixels were accepted.
	hsv_pixel_t expected_hsv[$];

	// Exact integer conversion of one pixel.
	function automatic hsv_pixel_t convert_rgb_to_hsv(
		input logic [CHANNEL_BITS-1:0] r,
		input logic [CHANNEL_BITS-1:0] g,
		input logic [CHANNEL_BITS-1:0] b
	);
		longint rv, gv, bv, top, bottom, delta, num, sextant, circle;
		hsv_pixel_t px;
		rv = longint'(r);
		gv = longint'(g);
		bv = longint'(b);
		sextant = longint'(rgb_hsv_pkg::HUE_SEXTANT);
		circle = longint'(rgb_hsv_pkg::HUE_CIRCLE);
		top = (rv > gv) ? rv : gv;
		top = (top > bv) ? top : bv;
		bottom = (rv < gv) ? rv : gv;
		bottom = (bottom < bv) ? bottom : bv;
		delta = top - bottom;
		px = '0;
		px.brightness = top[CHANNEL_BITS-1:0];
		if (delta == 0) begin
			// Grey and black pixels have no hue.
			px.hue_undefined = 1'b1;
		end else begin
			num = (delta * CHANNEL_MAX) / top;
			px.saturation = num[CHANNEL_BITS-1:0];
			// The largest channel picks the sector; red wins ties, then green.
			if (rv == top)
				num = sextant * (gv - bv);
			else if (gv == top)
				num = 2 * sextant * delta + sextant * (bv - rv);
			else
				num = 4 * sextant * delta + sextant * (rv - gv);
			if (num < 0)
				num = num + circle * delta;
			num = num / delta;
			px.hue = num[rgb_hsv_pkg::HUE_W-1:0];
		end
		return px;
	endfunction

	// Results are checked before new pixels are queued in the same cycle.
	always @(posedge clk or negedge arst_n) begin
		hsv_pixel_t want;
		if (!arst_n) begin
			expected_hsv.delete();
			fail_count <= 0;
			pending_count <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_hsv.size() == 0) begin
					$error("Result transaction arrived with no pixel waiting");
					fail_count <= fail_count + 1;
				end else begin
					want = expected_hsv.pop_front();
					if ({hue, saturation, brightness, hue_undefined} != want) begin
						fail_count <= fail_count + 1;
						if (hue != want.hue)
							$error("hue: expected %0d, actual %0d", want.hue, hue);
						if (saturation != want.saturation)
							$error("saturation: expected %0d, actual %0d",
								want.saturation, saturation);
						if (brightness != want.brightness)
							$error("brightness: expected %0d, actual %0d",
								want.brightness, brightness);
						if (hue_undefined != want.hue_undefined)
							$error("hue_undefined: expected %0d, actual %0d",
								want.hue_undefined, hue_undefined);
					end
				end
			end
			if (in_valid && in_ready)
				expected_hsv.push_back(convert_rgb_to_hsv(red, green, blue));
			pending_count <= expected_hsv.size();
		end
	end

endmodule : hsv_result_checker

[tb/sv/rgb_to_hsv_converter_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGB to HSV converter test
// Drives directed and random pixels into the converter with random idling on
// both channels, a long output stall and a full drain, and reports the verdict
// from the failure and pending counts of the result checker.
// ----------------------------------------------------------------------------
module rgb_to_hsv_converter_test;

	localparam int unsigned CH_BITS = 8;
	localparam int unsigned CH_MAX = (1 << CH_BITS) - 1;
	localparam int unsigned RANDOM_PIXELS = 1030;
	localparam int unsigned CALM_FROM = 880;
	localparam int unsigned HOLD_CYCLES = 40;
	localparam int unsigned DRAIN_CYCLES = 20;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [CH_BITS-1:0] red = '0;
	logic [CH_BITS-1:0] green = '0;
	logic [CH_BITS-1:0] blue = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [rgb_hsv_pkg::HUE_W-1:0] hue;
	logic [CH_BITS-1:0] saturation;
	logic [CH_BITS-1:0] brightness;
	logic hue_undefined;
	int fail_count;
	int pending_count;

	// Shared idling controls between the pixel and result processes.
	bit idle_on = 1'b0;
	bit calm = 1'b0;
	bit hold_output = 1'b0;

	rgb_to_hsv_converter #(
		.CHANNEL_BITS(CH_BITS)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.red(red),
		.green(green),
		.blue(blue),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.hue(hue),
		.saturation(saturation),
		.brightness(brightness),
		.hue_undefined(hue_undefined)
	);

	hsv_result_checker #(
		.CHANNEL_BITS(CH_BITS)
	) i_checker (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.red(red),
		.green(green),
		.blue(blue),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.hue(hue),
		.saturation(saturation),
		.brightness(brightness),
		.hue_undefined(hue_undefined),
		.fail_count(fail_count),
		.pending_count(pending_count)
	);

	// Clock with a 2 ns period.
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Offer one pixel and wait until the transaction is accepted, then sometimes
	// idle for a random burst when idling is enabled.
	task automatic send_pixel(
		input logic [CH_BITS-1:0] r,
		input logic [CH_BITS-1:0] g,
		input logic [CH_BITS-1:0] b
	);
		in_valid <= 1'b1;
		red <= r;
		green <= g;
		blue <= b;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		if (!calm && idle_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
	endtask

	// Random pixel drawn from a mix of general, grey, tied and edge values.
	task automatic send_random_pixel();
		logic [CH_BITS-1:0] r, g, b, peak;
		int unsigned kind;
		kind = $urandom_range(0, 99);
		r = CH_BITS'($urandom_range(0, CH_MAX));
		g = CH_BITS'($urandom_range(0, CH_MAX));
		b = CH_BITS'($urandom_range(0, CH_MAX));
		if (kind < 12) begin
			g = r;
			b = r;
		end else if (kind < 30) begin
			// At least two channels share the maximum.
			peak = CH_BITS'($urandom_range(1, CH_MAX));
			r = CH_BITS'($urandom_range(0, peak));
			g = CH_BITS'($urandom_range(0, peak));
			b = CH_BITS'($urandom_range(0, peak));
			case ($urandom_range(0, 2))
				0: begin
					r = peak;
					g = peak;
				end
				1: begin
					g = peak;
					b = peak;
				end
				default: begin
					r = peak;
					b = peak;
				end
			endcase
		end else if (kind < 40) begin
			r = CH_BITS'($urandom_range(0, 3));
			g = CH_BITS'($urandom_range(0, 3));
			b = CH_BITS'($urandom_range(0, 3));
		end else if (kind < 50) begin
			r = $urandom_range(0, 1) ? CH_BITS'(CH_MAX - $urandom_range(0, 1))
				: CH_BITS'($urandom_range(0, 1));
			g = $urandom_range(0, 1) ? CH_BITS'(CH_MAX - $urandom_range(0, 1))
				: CH_BITS'($urandom_range(0, 1));
			b = $urandom_range(0, 1) ? CH_BITS'(CH_MAX - $urandom_range(0, 1))
				: CH_BITS'($urandom_range(0, 1));
		end
		send_pixel(r, g, b);
	endtask

	// Result side: random stalls, and one long hold-off on request.
	initial begin
		forever begin
			if (hold_output) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_output = 1'b0;
			end else if (!calm && idle_on && $urandom_range(0, 3) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 5)) @(posedge clk);
			end else begin
				out_ready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	// Pixel stimulus and verdict.
	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed pixels: grey, black, white, primaries, ties and hue wrap.
		idle_on = 1'b1;
		send_pixel(8'd0, 8'd0, 8'd0);
		send_pixel(8'd255, 8'd255, 8'd255);
		send_pixel(8'd128, 8'd128, 8'd128);
		send_pixel(8'd1, 8'd1, 8'd1);
		send_pixel(8'd255, 8'd0, 8'd0);
		send_pixel(8'd0, 8'd255, 8'd0);
		send_pixel(8'd0, 8'd0, 8'd255);
		send_pixel(8'd255, 8'd255, 8'd0);
		send_pixel(8'd0, 8'd255, 8'd255);
		send_pixel(8'd255, 8'd0, 8'd255);
		send_pixel(8'd255, 8'd0, 8'd1);
		send_pixel(8'd255, 8'd0, 8'd254);
		send_pixel(8'd1, 8'd0, 8'd0);
		send_pixel(8'd0, 8'd1, 8'd0);
		send_pixel(8'd0, 8'd0, 8'd1);
		send_pixel(8'd1, 8'd1, 8'd0);
		send_pixel(8'd0, 8'd1, 8'd1);
		send_pixel(8'd1, 8'd0, 8'd1);
		send_pixel(8'd255, 8'd254, 8'd0);
		send_pixel(8'd254, 8'd255, 8'd255);
		send_pixel(8'd200, 8'd100, 8'd50);
		send_pixel(8'd10, 8'd250, 8'd3);
		send_pixel(8'd3, 8'd7, 8'd250);
		send_pixel(8'd170, 8'd85, 8'd170);

		// Random pixels in phases with and without idling.
		for (int unsigned n = 0; n < RANDOM_PIXELS; n++) begin
			if (n % 100 == 0)
				idle_on = ($urandom_range(0, 2) != 0);
			if (n == CALM_FROM)
				calm = 1'b1;
			// Long output stall while pixels keep coming, so the input backs up.
			if (n == 300)
				hold_output = 1'b1;
			// Let the pipeline drain completely before going on.
			if (n == 600) begin
				in_valid <= 1'b0;
				@(posedge clk);
				while (pending_count != 0)
					@(posedge clk);
			end
			send_random_pixel();
		end
		in_valid <= 1'b0;

		while (pending_count != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0 && pending_count == 0)
			$display("rgb_to_hsv_converter_test: PASS");
		else
			$display("rgb_to_hsv_converter_test: FAIL");
		$finish;
	end

	// Watchdog for a hung handshake.
	initial begin
		#200000;
		$display("rgb_to_hsv_converter_test: FAIL");
		$finish;
	end

endmodule : rgb_to_hsv_converter_test

[filelist.f]
rtl/core/rgb_hsv_pkg.sv
rtl/core/rgb_hsv_divider.sv
rtl/core/rgb_to_hsv_converter.sv
tb/sv/hsv_result_checker.sv
tb/sv/rgb_to_hsv_converter_test.sv
